// ===== rtl/core/mipsx_pkg.sv =====
package mipsx_pkg;

  localparam logic [31:0] UPPER_MASK     = 32'hF000_0000;
  localparam logic [31:0] GP_RESET       = 32'h0000_1800;
  localparam logic [31:0] SP_RESET       = 32'h0000_3FFC;
  localparam logic [31:0] PC_LIMIT_RESET = 32'h0000_0044;

  localparam logic [4:0] REG_V0 = 5'd2;
  localparam logic [4:0] REG_A0 = 5'd4;
  localparam logic [4:0] REG_GP = 5'd28;
  localparam logic [4:0] REG_SP = 5'd29;
  localparam logic [4:0] REG_RA = 5'd31;

  localparam logic [5:0] OP_SPECIAL = 6'h00, OP_J = 6'h02, OP_JAL = 6'h03, OP_BEQ = 6'h04,
                         OP_BNE = 6'h05, OP_BLEZ = 6'h06, OP_BGTZ = 6'h07, OP_ADDI = 6'h08,
                         OP_ADDIU = 6'h09, OP_SLTI = 6'h0A, OP_SLTIU = 6'h0B, OP_ANDI = 6'h0C,
                         OP_ORI = 6'h0D, OP_XORI = 6'h0E, OP_LUI = 6'h0F, OP_LB = 6'h20,
                         OP_LH = 6'h21, OP_LW = 6'h23, OP_LBU = 6'h24, OP_LHU = 6'h25,
                         OP_SB = 6'h28, OP_SH = 6'h29, OP_SW = 6'h2B;
  localparam logic [5:0] F_SLL = 6'h00, F_SRL = 6'h02, F_SRA = 6'h03,
                         F_JR = 6'h08, F_SYSCALL = 6'h0C, F_MFHI = 6'h10, F_MFLO = 6'h12,
                         F_MULT = 6'h18, F_DIV = 6'h1A, F_ADD = 6'h20, F_ADDU = 6'h21,
                         F_SUB = 6'h22, F_AND = 6'h24, F_OR = 6'h25, F_XOR = 6'h26,
                         F_NOR = 6'h27, F_SLT = 6'h2A, F_SLTU = 6'h2B;
  localparam logic [31:0] SC_PINT = 32'd1, SC_PSTR = 32'd4, SC_EXIT = 32'd10;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_OPC  = 3'd1;
  localparam logic [2:0] ST_BAD_FN   = 3'd2;
  localparam logic [2:0] ST_HALTED   = 3'd3;
  localparam logic [2:0] ST_LOAD_SEQ = 3'd4;

  localparam logic [2:0] SYS_NONE  = 3'd0;
  localparam logic [2:0] SYS_PINT  = 3'd1;
  localparam logic [2:0] SYS_PSTR  = 3'd2;
  localparam logic [2:0] SYS_EXIT  = 3'd3;
  localparam logic [2:0] SYS_UNK   = 3'd4;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [1:0]  mem_kind;
    logic [31:0] mem_addr;
    logic [1:0]  acc_size;
    logic [31:0] store_data;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic [2:0]  sys_event;
    logic [31:0] sys_arg;
    logic [2:0]  status;
  } result_t;

  typedef struct packed {
    logic start;   // latch item, read operands
    logic exec;    // evaluate, maybe launch multiply/divide
    logic commit;  // write back state, form result
  } cmd_t;

  typedef struct packed {
    logic long_op;  // mult/div needs the iterative unit
    logic md_done;
  } sts_t;

endpackage

// ===== rtl/core/mipsx_ctrl.sv =====
module mipsx_ctrl
  import mipsx_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic out_free,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_EX   = 5'b00100,
    S_MD   = 5'b01000,
    S_WB   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_RD;
      S_RD:   state_nxt = S_EX;
      S_EX:   state_nxt = sts.long_op ? S_MD : S_WB;
      S_MD:   if (sts.md_done) state_nxt = S_WB;
      S_WB:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign cmd.start  = in_fire;
  assign cmd.exec   = (state_r == S_RD);
  assign cmd.commit = (state_r == S_WB) && out_free;
  assign busy       = (state_r != S_IDLE);

endmodule

// ===== rtl/core/mipsx_muldiv.sv =====
module mipsx_muldiv
  import mipsx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        is_div,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] hi,
  output logic [31:0] lo
);

  logic        run_r;
  logic [5:0]  cnt_r;
  logic        div_r, na_r, nb_r, bz_r;
  logic [31:0] a_r, b_r, q_r, rem_r;
  logic [63:0] prod_r;
  logic [32:0] trial;
  logic [31:0] rsh;

  assign rsh   = {rem_r[30:0], q_r[31]};
  assign trial = {1'b0, rsh} - {1'b0, b_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= is_div ? 6'd32 : 6'd2;
    end else if (run_r) begin
      if (cnt_r == 6'd0) run_r <= 1'b0;
      else cnt_r <= cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= is_div;
      na_r  <= a[31];
      nb_r  <= b[31];
      bz_r  <= (b == 32'd0);
      a_r   <= a;
      b_r   <= (is_div && b[31]) ? 32'd0 - b : b;
      if (is_div) begin
        q_r   <= a[31] ? 32'd0 - a : a;
        rem_r <= '0;
      end
    end else if (run_r && cnt_r != 6'd0) begin
      if (div_r) begin
        if (!trial[32]) begin
          rem_r <= trial[31:0];
          q_r   <= {q_r[30:0], 1'b1};
        end else begin
          rem_r <= rsh;
          q_r   <= {q_r[30:0], 1'b0};
        end
      end else if (cnt_r == 6'd2) begin
        prod_r <= 64'($signed(a_r) * $signed(b_r));
      end
    end
  end

  assign done = run_r && (cnt_r == 6'd0);

  always_comb begin
    if (!div_r) begin
      hi = prod_r[63:32];
      lo = prod_r[31:0];
    end else if (bz_r) begin
      hi = a_r;
      lo = 32'hFFFF_FFFF;
    end else begin
      hi = na_r ? 32'd0 - rem_r : rem_r;
      lo = (na_r != nb_r) ? 32'd0 - q_r : q_r;
    end
  end

endmodule

// ===== rtl/core/mipsx_dp.sv =====
module mipsx_dp
  import mipsx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        in_op,
  input  logic [31:0] in_instr,
  input  logic [31:0] in_load_data,
  input  logic [31:0] pc_limit,
  output result_t     res
);

  logic [31:0] rf_r [32];
  logic [31:0] pc_r, hi_r, lo_r;
  logic        pend_r, halted_r;
  logic [9:0]  pinfo_r;
  logic        op_r;
  logic [31:0] ins_r, ld_r, a_r, b_r, v0_r, a0_r;
  result_t     res_r, ex;
  logic        wr_en;
  logic [4:0]  wr_idx;
  logic [31:0] wr_val, pc_n;
  logic        halt_n, pend_n, hilo_n, long_n, is_div;
  logic [9:0]  pinfo_n;
  logic        long_r, hilo_r, wr_en_r, halt_r, pend_set_r;
  logic        md_done;
  logic [31:0] md_hi, md_lo;

  logic [5:0]  opc, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [31:0] imm, simm, ea, brt, lv;

  assign opc  = ins_r[31:26];
  assign fn   = ins_r[5:0];
  assign rs   = ins_r[25:21];
  assign rt   = ins_r[20:16];
  assign rd   = ins_r[15:11];
  assign sh   = ins_r[10:6];
  assign imm  = {16'd0, ins_r[15:0]};
  assign simm = {{16{ins_r[15]}}, ins_r[15:0]};
  assign ea   = a_r + simm;
  assign brt  = pc_r + 32'd4 + {simm[29:0], 2'b00};

  always_comb begin
    lv = ld_r;
    unique case (pinfo_r[6:5])
      SZ_BYTE: begin
        lv = {24'd0, ld_r[8*pinfo_r[9:8] +: 8]};
        if (!pinfo_r[7]) lv = {{24{lv[7]}}, lv[7:0]};
      end
      SZ_HALF: begin
        lv = {16'd0, pinfo_r[9] ? ld_r[31:16] : ld_r[15:0]};
        if (!pinfo_r[7]) lv = {{16{lv[15]}}, lv[15:0]};
      end
      default: lv = ld_r;
    endcase
  end

  always_comb begin
    ex = '0;
    wr_en = 1'b0; wr_idx = '0; wr_val = '0;
    pc_n = pc_r; halt_n = halted_r; pend_n = pend_r; pinfo_n = pinfo_r;
    hilo_n = 1'b0; long_n = 1'b0; is_div = 1'b0;
    if (op_r) begin
      if (pend_r) begin
        wr_en = 1'b1; wr_idx = pinfo_r[4:0]; wr_val = lv;
        pend_n = 1'b0; pinfo_n = '0;
      end else begin
        ex.status = halted_r ? ST_HALTED : ST_LOAD_SEQ;
      end
    end else if (halted_r) begin
      ex.status = ST_HALTED;
    end else if (pend_r) begin
      ex.status = ST_LOAD_SEQ;
    end else begin
      pc_n = pc_r + 32'd4;
      unique case (opc)
        OP_SPECIAL: begin
          unique case (fn)
            F_ADD, F_ADDU: begin wr_en = 1'b1; wr_val = a_r + b_r; end
            F_SUB: begin wr_en = 1'b1; wr_val = a_r - b_r; end
            F_MULT: begin long_n = 1'b1; hilo_n = 1'b1; end
            F_DIV: begin long_n = 1'b1; hilo_n = 1'b1; is_div = 1'b1; end
            F_AND: begin wr_en = 1'b1; wr_val = a_r & b_r; end
            F_OR: begin wr_en = 1'b1; wr_val = a_r | b_r; end
            F_XOR: begin wr_en = 1'b1; wr_val = a_r ^ b_r; end
            F_NOR: begin wr_en = 1'b1; wr_val = ~(a_r | b_r); end
            F_SLT: begin wr_en = 1'b1; wr_val = {31'd0, $signed(a_r) < $signed(b_r)}; end
            F_SLTU: begin wr_en = 1'b1; wr_val = {31'd0, a_r < b_r}; end
            F_JR: pc_n = a_r;
            F_SLL: begin wr_en = 1'b1; wr_val = b_r << sh; end
            F_SRL: begin wr_en = 1'b1; wr_val = b_r >> sh; end
            F_SRA: begin wr_en = 1'b1; wr_val = 32'($signed(b_r) >>> sh); end
            F_MFHI: begin wr_en = 1'b1; wr_val = hi_r; end
            F_MFLO: begin wr_en = 1'b1; wr_val = lo_r; end
            F_SYSCALL: begin
              ex.sys_arg = a0_r;
              priority if (v0_r == SC_PINT) ex.sys_event = SYS_PINT;
              else if (v0_r == SC_PSTR) ex.sys_event = SYS_PSTR;
              else if (v0_r == SC_EXIT) begin
                ex.sys_event = SYS_EXIT; pc_n = 32'hFFFF_FFFF; halt_n = 1'b1;
              end else ex.sys_event = SYS_UNK;
            end
            default: ex.status = ST_BAD_FN;
          endcase
          wr_idx = rd;
        end
        OP_LW, OP_LB, OP_LBU, OP_LH, OP_LHU: begin
          ex.mem_kind = MEM_LOAD; ex.mem_addr = ea;
          ex.acc_size = (opc == OP_LW) ? SZ_WORD :
                        ((opc == OP_LH || opc == OP_LHU) ? SZ_HALF : SZ_BYTE);
          pend_n = 1'b1;
          pinfo_n = {ea[1:0], (opc == OP_LBU || opc == OP_LHU), ex.acc_size, rt};
        end
        OP_LUI: begin wr_en = 1'b1; wr_idx = rt; wr_val = {ins_r[15:0], 16'd0}; end
        OP_SW, OP_SB, OP_SH: begin
          ex.mem_kind = MEM_STORE; ex.mem_addr = ea; ex.store_data = b_r;
          ex.acc_size = (opc == OP_SW) ? SZ_WORD : ((opc == OP_SH) ? SZ_HALF : SZ_BYTE);
        end
        OP_BEQ: if (a_r == b_r) pc_n = brt;
        OP_BNE: if (a_r != b_r) pc_n = brt;
        OP_BLEZ: if (a_r == 32'd0 || a_r[31]) pc_n = brt;
        OP_BGTZ: if (a_r != 32'd0 && !a_r[31]) pc_n = brt;
        OP_ADDI, OP_ADDIU: begin wr_en = 1'b1; wr_idx = rt; wr_val = a_r + simm; end
        OP_SLTI: begin wr_en = 1'b1; wr_idx = rt;
          wr_val = {31'd0, $signed(a_r) < $signed(simm)}; end
        OP_SLTIU: begin wr_en = 1'b1; wr_idx = rt; wr_val = {31'd0, a_r < simm}; end
        OP_ANDI: begin wr_en = 1'b1; wr_idx = rt; wr_val = a_r & imm; end
        OP_ORI: begin wr_en = 1'b1; wr_idx = rt; wr_val = a_r | imm; end
        OP_XORI: begin wr_en = 1'b1; wr_idx = rt; wr_val = a_r ^ imm; end
        OP_JAL: begin
          wr_en = 1'b1; wr_idx = REG_RA; wr_val = pc_r + 32'd4;
          pc_n = ((pc_r + 32'd4) & UPPER_MASK) | {4'd0, ins_r[25:0], 2'b00};
        end
        OP_J: pc_n = ((pc_r + 32'd4) & UPPER_MASK) | {4'd0, ins_r[25:0], 2'b00};
        default: ex.status = ST_BAD_OPC;
      endcase
      if (pc_n == 32'd0 || pc_n >= pc_limit) halt_n = 1'b1;
    end
    if (wr_idx == 5'd0) wr_en = 1'b0;
    ex.reg_write = wr_en;
    ex.reg_index = wr_en ? wr_idx : 5'd0;
    ex.reg_value = wr_en ? wr_val : 32'd0;
    ex.next_pc   = pc_n;
  end

  mipsx_muldiv u_md (
    .clk(clk), .rst_n(rst_n), .start(cmd.exec && long_n), .is_div(is_div),
    .a(a_r), .b(b_r), .done(md_done), .hi(md_hi), .lo(md_lo)
  );

  assign sts.long_op = long_r;
  assign sts.md_done = md_done;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r <= in_op;
      ins_r <= in_instr;
      ld_r <= in_load_data;
      a_r  <= rf_r[in_instr[25:21]];
      b_r  <= rf_r[in_instr[20:16]];
      v0_r <= rf_r[REG_V0];
      a0_r <= rf_r[REG_A0];
    end
    if (cmd.exec) res_r <= ex;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 32; i++)
        rf_r[i] <= (i == REG_GP) ? GP_RESET : ((i == REG_SP) ? SP_RESET : 32'd0);
      pc_r <= '0; hi_r <= '0; lo_r <= '0;
      pend_r <= 1'b0; pinfo_r <= '0; halted_r <= 1'b0;
      long_r <= 1'b0; hilo_r <= 1'b0; wr_en_r <= 1'b0; halt_r <= 1'b0;
      pend_set_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        long_r <= long_n; hilo_r <= hilo_n; wr_en_r <= wr_en;
        halt_r <= halt_n; pend_set_r <= pend_n;
        pinfo_r <= pinfo_n;
      end
      if (cmd.commit) begin
        pc_r <= res_r.next_pc;
        halted_r <= halt_r;
        pend_r <= pend_set_r;
        if (wr_en_r) rf_r[res_r.reg_index] <= res_r.reg_value;
        if (hilo_r) begin hi_r <= md_hi; lo_r <= md_lo; end
      end
    end
  end

  assign res = res_r;

endmodule

// ===== rtl/core/mips_integer_instruction_executor_top.sv =====
// channel | dir | handshake              | payload
// in      | in  | in_tvalid/in_tready    | in_tuser=op, in_tdata={load_data,instr}
// out     | out | out_tvalid/out_tready  | out_tdata=result fields
// cfg     | in  | cfg_valid/cfg_ready    | cfg_data=PC limit
// One item at a time: read, execute and write-back states, with a multiply/divide state for
// MULT and DIV; DIV runs in the radix-2 divider (one quotient bit a cycle).
// Result held in an output register until taken; next item accepted the cycle after.
// rst_n is synchronous; reset loads gp/sp and PC limit = 0x44; no beats taken in reset.
module mips_integer_instruction_executor_top
  import mipsx_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // instr[31:0], load_data[63:32]
  input  logic         in_tuser,   // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [175:0] out_tdata,  // next_pc, mem_kind, mem_addr, acc_size, store_data,
                                   // reg_write, reg_index, reg_value, sys_event, sys_arg,
                                   // status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);

  cmd_t    cmd;
  sts_t    sts;
  result_t res;
  logic    busy, ov_r, in_fire;
  logic [31:0] pc_limit_r;

  assign in_tready = rst_n && !busy && !ov_r;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) pc_limit_r <= PC_LIMIT_RESET;
    else if (cfg_valid && cfg_ready) pc_limit_r <= cfg_data;
  end

  mipsx_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(!ov_r),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  mipsx_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_op(in_tuser),
    .in_instr(in_tdata[31:0]), .in_load_data(in_tdata[63:32]),
    .pc_limit(pc_limit_r), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.commit) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_tdata <= {res.status, res.sys_arg, res.sys_event,
      res.reg_value, res.reg_index, res.reg_write, res.store_data, res.acc_size,
      res.mem_addr, res.mem_kind, res.next_pc};
  end

  assign out_tvalid = ov_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready) else $error("accept while busy");
  a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> !cmd.commit) else $error("double commit");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata)) else $error("out changed");

endmodule
